@@ hdl/bats_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bats_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int CLASS_BITS = 4;

  localparam int X_BITS    = $clog2(MAX_WIDTH);
  localparam int Y_BITS    = $clog2(MAX_HEIGHT);
  localparam int ADDR_BITS = X_BITS + Y_BITS;
  localparam int CELLS     = MAX_WIDTH * MAX_HEIGHT;

  localparam int DIM_BITS     = 7;
  localparam int PICK_BITS    = 8;
  localparam int TX_BITS      = 8;
  localparam int TY_BITS      = 7;
  localparam int MASK_BITS    = 8;
  localparam int DIRS         = 8;
  localparam int DIR_BITS     = 3;
  localparam int SCAN_BITS    = 4;
  localparam int OFFSETS      = 68;
  localparam int SEL_BITS     = 7;
  localparam int CNT_BITS     = 4;
  localparam int SHIFT_BITS   = 3;
  localparam int SHIFT_TOP    = 6;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_HEIGHT = 2'd1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_KEY,
    ST_MOD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                  flag;
    logic [CLASS_BITS-1:0] cls;
  } cell_t;

  typedef struct packed {
    logic                found;
    logic [SEL_BITS-1:0] start;
    logic [CNT_BITS-1:0] count;
  } key_info_t;

  typedef struct packed {
    logic                  load;
    logic                  step;
    logic [SHIFT_BITS-1:0] shift;
    logic [PICK_BITS-1:0]  pick;
    logic [CNT_BITS-1:0]   divisor;
  } mod_ctrl_t;

  typedef struct packed {
    state_t state;
    logic   mem_we;
  } seq_status_t;

  // Neighbor steps in mask bit order: NW, N, NE, W, E, SW, S, SE.
  localparam logic signed [1:0] STEP_X [DIRS] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1,
                                                  2'sd1, -2'sd1, 2'sd0, 2'sd1};
  localparam logic signed [1:0] STEP_Y [DIRS] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0,
                                                  2'sd0, 2'sd1, 2'sd1, 2'sd1};

  localparam logic [TX_BITS-1:0] OFFSET_X [OFFSETS] = '{
    8'd0,   8'd48,  8'd80,  8'd48,  8'd0,   8'd64,  8'd16,  8'd16,  8'd32,  8'd144,
    8'd144, 8'd96,  8'd32,  8'd0,   8'd0,   8'd0,   8'd80,  8'd128, 8'd112, 8'd64,
    8'd144, 8'd128, 8'd128, 8'd0,   8'd16,  8'd32,  8'd96,  8'd96,  8'd48,  8'd144,
    8'd48,  8'd112, 8'd48,  8'd112, 8'd48,  8'd64,  8'd16,  8'd96,  8'd16,  8'd128,
    8'd96,  8'd32,  8'd96,  8'd80,  8'd32,  8'd112, 8'd64,  8'd80,  8'd0,   8'd16,
    8'd32,  8'd48,  8'd64,  8'd80,  8'd0,   8'd16,  8'd32,  8'd48,  8'd64,  8'd80,
    8'd32,  8'd16,  8'd32,  8'd48,  8'd64,  8'd80,  8'd64,  8'd80
  };

  localparam logic [TY_BITS-1:0] OFFSET_Y [OFFSETS] = '{
    7'd80,  7'd96,  7'd112, 7'd80,  7'd96,  7'd112, 7'd80,  7'd96,  7'd96,  7'd32,
    7'd80,  7'd80,  7'd80,  7'd32,  7'd48,  7'd64,  7'd96,  7'd32,  7'd80,  7'd96,
    7'd48,  7'd80,  7'd48,  7'd112, 7'd112, 7'd112, 7'd48,  7'd112, 7'd48,  7'd64,
    7'd64,  7'd64,  7'd112, 7'd112, 7'd112, 7'd64,  7'd48,  7'd64,  7'd64,  7'd64,
    7'd32,  7'd112, 7'd96,  7'd64,  7'd48,  7'd96,  7'd80,  7'd80,  7'd0,   7'd0,
    7'd0,   7'd0,   7'd0,   7'd0,   7'd16,  7'd16,  7'd16,  7'd16,  7'd16,  7'd16,
    7'd64,  7'd32,  7'd32,  7'd32,  7'd32,  7'd32,  7'd48,  7'd48
  };

  // Mask to first offset slot and variant count; found is low for unknown masks.
  function automatic key_info_t key_lookup(input logic [MASK_BITS-1:0] mask);
    key_info_t r;
    r = '0;
    case (mask)
      8'd2:    r = '{1'b1, 7'd0,  4'd1};
      8'd8:    r = '{1'b1, 7'd1,  4'd1};
      8'd10:   r = '{1'b1, 7'd2,  4'd1};
      8'd11:   r = '{1'b1, 7'd3,  4'd1};
      8'd16:   r = '{1'b1, 7'd4,  4'd1};
      8'd18:   r = '{1'b1, 7'd5,  4'd1};
      8'd22:   r = '{1'b1, 7'd6,  4'd1};
      8'd24:   r = '{1'b1, 7'd7,  4'd2};
      8'd26:   r = '{1'b1, 7'd9,  4'd1};
      8'd27:   r = '{1'b1, 7'd10, 4'd1};
      8'd30:   r = '{1'b1, 7'd11, 4'd1};
      8'd31:   r = '{1'b1, 7'd12, 4'd1};
      8'd64:   r = '{1'b1, 7'd13, 4'd1};
      8'd66:   r = '{1'b1, 7'd14, 4'd2};
      8'd72:   r = '{1'b1, 7'd16, 4'd1};
      8'd74:   r = '{1'b1, 7'd17, 4'd1};
      8'd75:   r = '{1'b1, 7'd18, 4'd1};
      8'd80:   r = '{1'b1, 7'd19, 4'd1};
      8'd82:   r = '{1'b1, 7'd20, 4'd1};
      8'd86:   r = '{1'b1, 7'd21, 4'd1};
      8'd88:   r = '{1'b1, 7'd22, 4'd1};
      8'd90:   r = '{1'b1, 7'd23, 4'd2};
      8'd91:   r = '{1'b1, 7'd25, 4'd1};
      8'd94:   r = '{1'b1, 7'd26, 4'd1};
      8'd95:   r = '{1'b1, 7'd27, 4'd1};
      8'd104:  r = '{1'b1, 7'd28, 4'd1};
      8'd106:  r = '{1'b1, 7'd29, 4'd1};
      8'd107:  r = '{1'b1, 7'd30, 4'd1};
      8'd120:  r = '{1'b1, 7'd31, 4'd1};
      8'd122:  r = '{1'b1, 7'd32, 4'd1};
      8'd123:  r = '{1'b1, 7'd33, 4'd1};
      8'd126:  r = '{1'b1, 7'd34, 4'd1};
      8'd127:  r = '{1'b1, 7'd35, 4'd1};
      8'd208:  r = '{1'b1, 7'd36, 4'd1};
      8'd210:  r = '{1'b1, 7'd37, 4'd1};
      8'd214:  r = '{1'b1, 7'd38, 4'd1};
      8'd216:  r = '{1'b1, 7'd39, 4'd1};
      8'd218:  r = '{1'b1, 7'd40, 4'd1};
      8'd219:  r = '{1'b1, 7'd41, 4'd1};
      8'd222:  r = '{1'b1, 7'd42, 4'd1};
      8'd223:  r = '{1'b1, 7'd43, 4'd1};
      8'd248:  r = '{1'b1, 7'd44, 4'd1};
      8'd250:  r = '{1'b1, 7'd45, 4'd1};
      8'd251:  r = '{1'b1, 7'd46, 4'd1};
      8'd254:  r = '{1'b1, 7'd47, 4'd1};
      8'd255:  r = '{1'b1, 7'd48, 4'd13};
      8'd0:    r = '{1'b1, 7'd61, 4'd7};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/bats_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bats_req_if
  import bats_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [X_BITS-1:0]     cell_x;
  logic [Y_BITS-1:0]     cell_y;
  logic [CLASS_BITS-1:0] tile_class;
  logic                  needs_autotile;
  logic [PICK_BITS-1:0]  variant_pick;

  modport source (output valid, op, cell_x, cell_y, tile_class, needs_autotile,
                  variant_pick, input ready);
  modport sink (input valid, op, cell_x, cell_y, tile_class, needs_autotile,
                variant_pick, output ready);
endinterface

`default_nettype wire

@@ hdl/bats_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bats_rsp_if
  import bats_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [TX_BITS-1:0]   tileset_x;
  logic [TY_BITS-1:0]   tileset_y;
  logic [MASK_BITS-1:0] neighbour_mask;
  logic                 autotiled;
  logic                 key_missing;

  modport source (output valid, tileset_x, tileset_y, neighbour_mask, autotiled,
                  key_missing, input ready);
  modport sink (input valid, tileset_x, tileset_y, neighbour_mask, autotiled,
                key_missing, output ready);
endinterface

`default_nettype wire

@@ hdl/bats_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bats_cfg_if
  import bats_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [DIM_BITS-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/bats_grid_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bats_grid_mem
  import bats_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  cell_t                wdata,
  output cell_t                rdata
);

  cell_t mem [CELLS];

  // Single port, registered read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/bats_mod_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bats_mod_unit
  import bats_pkg::*;
(
  input  logic                 clk,
  input  mod_ctrl_t            ctrl,
  output logic [PICK_BITS-1:0] rem
);

  localparam int CMP_BITS = PICK_BITS + (1 << SHIFT_BITS);

  logic [CMP_BITS-1:0] sub_val;
  logic                fits;

  // One restoring step: subtract divisor << shift when it fits.
  assign sub_val = CMP_BITS'(ctrl.divisor) << ctrl.shift;
  assign fits    = CMP_BITS'(rem) >= sub_val;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= ctrl.pick;
    end else if (ctrl.step && fits) begin
      rem <= rem - sub_val[PICK_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

@@ hdl/bats_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bats_ctrl
  import bats_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  bats_req_if.sink             req,
  bats_rsp_if.source           rsp,
  input  logic [DIM_BITS-1:0]  grid_w,
  input  logic [DIM_BITS-1:0]  grid_h,
  output logic                 mem_en,
  output logic                 mem_we,
  output logic [ADDR_BITS-1:0] mem_addr,
  output cell_t                mem_wdata,
  input  cell_t                mem_rdata,
  output mod_ctrl_t            mod_ctrl,
  input  logic [PICK_BITS-1:0] mod_rem,
  output seq_status_t          status
);

  state_t state, state_next;

  logic [SCAN_BITS-1:0]  cnt;
  logic [SHIFT_BITS-1:0] shift;
  logic [X_BITS-1:0]     x_q;
  logic [Y_BITS-1:0]     y_q;
  logic [PICK_BITS-1:0]  pick_q;
  logic [CLASS_BITS-1:0] own_q;
  logic                  flag_q;
  logic                  zero_q;
  logic [DIRS-1:0]       match_q;
  logic [MASK_BITS-1:0]  mask_q;
  key_info_t             key_q;

  logic                  rsp_valid;
  logic [TX_BITS-1:0]    tx_q;
  logic [TY_BITS-1:0]    ty_q;
  logic [MASK_BITS-1:0]  rmask_q;
  logic                  auto_q;
  logic                  miss_q;

  logic                  accept;
  logic                  inside_req;
  logic [DIRS-1:0]       inb;
  logic [DIR_BITS-1:0]   dir;
  logic [DIR_BITS-1:0]   prev_dir;
  logic [X_BITS-1:0]     nx;
  logic [Y_BITS-1:0]     ny;
  logic [MASK_BITS-1:0]  mask_c;
  logic                  emit_go;
  logic [SEL_BITS-1:0]   sel;
  logic [TX_BITS-1:0]    sel_x;
  logic [TY_BITS-1:0]    sel_y;

  assign req.ready  = (state == ST_IDLE);
  assign accept     = req.valid && req.ready;
  assign inside_req = (DIM_BITS'(req.cell_x) < grid_w) && (DIM_BITS'(req.cell_y) < grid_h);

  // Per-direction grid bounds of the held cell.
  always_comb begin
    for (int i = 0; i < DIRS; i++) begin
      logic ok_x;
      logic ok_y;
      ok_x = 1'b1;
      ok_y = 1'b1;
      if (STEP_X[i] == -2'sd1) ok_x = (x_q != '0);
      if (STEP_X[i] == 2'sd1)  ok_x = (DIM_BITS'(x_q) + DIM_BITS'(1)) < grid_w;
      if (STEP_Y[i] == -2'sd1) ok_y = (y_q != '0);
      if (STEP_Y[i] == 2'sd1)  ok_y = (DIM_BITS'(y_q) + DIM_BITS'(1)) < grid_h;
      inb[i] = ok_x && ok_y;
    end
  end

  assign dir      = cnt[DIR_BITS-1:0];
  assign prev_dir = DIR_BITS'(cnt - SCAN_BITS'(1));
  assign nx       = x_q + X_BITS'(STEP_X[dir]);
  assign ny       = y_q + Y_BITS'(STEP_Y[dir]);

  // Corners also need both adjacent edges.
  assign mask_c = {match_q[7] & match_q[4] & match_q[6],
                   match_q[6],
                   match_q[5] & match_q[3] & match_q[6],
                   match_q[4],
                   match_q[3],
                   match_q[2] & match_q[1] & match_q[4],
                   match_q[1],
                   match_q[0] & match_q[1] & match_q[3]};

  assign emit_go = !rsp_valid || rsp.ready;

  assign sel   = key_q.start + ((key_q.count > CNT_BITS'(1)) ? SEL_BITS'(mod_rem) : '0);
  assign sel_x = (sel < SEL_BITS'(OFFSETS)) ? OFFSET_X[sel] : '0;
  assign sel_y = (sel < SEL_BITS'(OFFSETS)) ? OFFSET_Y[sel] : '0;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && req.op == OP_QUERY) begin
          state_next = inside_req ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (cnt == SCAN_BITS'(DIRS)) state_next = ST_KEY;
      end
      ST_KEY: begin
        state_next = ST_MOD;
      end
      ST_MOD: begin
        if (shift == '0) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory and divider controls.
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = {req.cell_y, req.cell_x};
    mem_wdata = '{flag: req.needs_autotile, cls: req.tile_class};
    mod_ctrl  = '{load: 1'b0, step: 1'b0, shift: shift, pick: pick_q,
                  divisor: key_q.count};
    case (state)
      ST_IDLE: begin
        mem_en = accept && inside_req;
        mem_we = accept && inside_req && (req.op == OP_WRITE);
      end
      ST_SCAN: begin
        mem_en   = (cnt < SCAN_BITS'(DIRS));
        mem_addr = {ny, nx};
      end
      ST_KEY: begin
        mod_ctrl.load = 1'b1;
      end
      ST_MOD: begin
        mod_ctrl.step = 1'b1;
      end
      default: begin
        mem_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EMIT && emit_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          x_q    <= req.cell_x;
          y_q    <= req.cell_y;
          pick_q <= req.variant_pick;
          zero_q <= !inside_req;
          cnt    <= '0;
        end
      end
      ST_SCAN: begin
        if (cnt == '0) begin
          own_q  <= mem_rdata.cls;
          flag_q <= mem_rdata.flag;
        end else begin
          match_q[prev_dir] <= inb[prev_dir] && (mem_rdata.cls == own_q);
        end
        cnt <= cnt + SCAN_BITS'(1);
      end
      ST_KEY: begin
        mask_q <= mask_c;
        key_q  <= key_lookup(mask_c);
        zero_q <= !flag_q;
        shift  <= SHIFT_BITS'(SHIFT_TOP);
      end
      ST_MOD: begin
        shift <= shift - SHIFT_BITS'(1);
      end
      ST_EMIT: begin
        if (emit_go) begin
          if (zero_q) begin
            tx_q    <= '0;
            ty_q    <= '0;
            rmask_q <= '0;
            auto_q  <= 1'b0;
            miss_q  <= 1'b0;
          end else begin
            tx_q    <= key_q.found ? sel_x : '0;
            ty_q    <= key_q.found ? sel_y : '0;
            rmask_q <= mask_q;
            auto_q  <= 1'b1;
            miss_q  <= !key_q.found;
          end
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.tileset_x      = tx_q;
  assign rsp.tileset_y      = ty_q;
  assign rsp.neighbour_mask = rmask_q;
  assign rsp.autotiled      = auto_q;
  assign rsp.key_missing    = miss_q;

  assign status = '{state: state, mem_we: mem_we};

endmodule

`default_nettype wire

@@ hdl/blob_autotile_selector_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Blob autotile selector: picks a 47-tile blob tileset offset for a grid cell.
// Channels (valid/ready, a word moves when both are high):
//   req - input words. op = write stores tile_class and needs_autotile at
//         (cell_x, cell_y); op = query asks for the tile choice of that cell.
//   rsp - one word per query: tileset offset, neighbor mask, autotiled and
//         key_missing. Writes give no word.
//   cfg - register writes, index 0 grid_width, index 1 grid_height; always
//         ready. Zero reads as 1, values above 64 saturate to 64.
// Timing: writes are taken back to back. An in-grid query reads the
// cell and its eight neighbors one per cycle from the single-port grid RAM,
// then looks up the mask and runs a 7-step restoring remainder for the variant
// pick, then registers the result word; req is ready again in the same cycle
// that the result word turns valid. An out-of-grid query skips the scan and
// goes straight to the result. req is not ready while a query is in flight.
// Reset loads 64 x 64 and empties the result register; the grid RAM is not
// cleared, so query only cells that were written. If rsp stalls, the finished
// result waits in the sequencer until the output register frees up.

module blob_autotile_selector_top
  import bats_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  bats_req_if.sink   req,
  bats_rsp_if.source rsp,
  bats_cfg_if.sink   cfg
);

  logic [DIM_BITS-1:0]  grid_w;
  logic [DIM_BITS-1:0]  grid_h;
  logic [DIM_BITS-1:0]  w_clamp;
  logic [DIM_BITS-1:0]  h_clamp;

  logic                 mem_en;
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_addr;
  cell_t                mem_wdata;
  cell_t                mem_rdata;
  mod_ctrl_t            mod_ctrl;
  logic [PICK_BITS-1:0] mod_rem;
  seq_status_t          st;

  // Config port never stalls.
  assign cfg.ready = 1'b1;

  // Clamp written dimensions to 1..MAX.
  always_comb begin
    w_clamp = cfg.data;
    h_clamp = cfg.data;
    if (cfg.data == '0) begin
      w_clamp = DIM_BITS'(1);
      h_clamp = DIM_BITS'(1);
    end
    if (cfg.data > DIM_BITS'(MAX_WIDTH))  w_clamp = DIM_BITS'(MAX_WIDTH);
    if (cfg.data > DIM_BITS'(MAX_HEIGHT)) h_clamp = DIM_BITS'(MAX_HEIGHT);
  end

  // Hold grid dimensions; unknown indexes drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_w <= DIM_BITS'(MAX_WIDTH);
      grid_h <= DIM_BITS'(MAX_HEIGHT);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_GRID_WIDTH:  grid_w <= w_clamp;
        CFG_GRID_HEIGHT: grid_h <= h_clamp;
        default:         grid_w <= grid_w;
      endcase
    end
  end

  // Sequencer: handshakes, neighbor scan, key lookup, result register.
  bats_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .grid_w    (grid_w),
    .grid_h    (grid_h),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .mod_ctrl  (mod_ctrl),
    .mod_rem   (mod_rem),
    .status    (st)
  );

  // Class and flag per cell, row-major.
  bats_grid_mem u_grid (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // One compare-subtract unit, reused for every step of the variant remainder.
  bats_mod_unit u_mod (
    .clk  (clk),
    .ctrl (mod_ctrl),
    .rem  (mod_rem)
  );

  // A query leaves idle for the scan or straight to the result.
  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.op == OP_QUERY |=>
      st.state == ST_SCAN || st.state == ST_EMIT)
    else $error("query did not start the sequencer");

  // A finished result waits while the output register is stalled.
  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    st.state == ST_EMIT && rsp.valid && !rsp.ready |=> st.state == ST_EMIT)
    else $error("result dropped under stall");

  // A missing key only comes from an autotiled cell.
  a_miss_auto: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.key_missing |-> rsp.autotiled)
    else $error("key_missing without autotiled");

  // Cells not autotiled report all zero.
  a_plain_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.autotiled |->
      rsp.neighbour_mask == '0 && rsp.tileset_x == '0 && rsp.tileset_y == '0)
    else $error("non-autotiled result not zero");

  // The grid is written only between queries.
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    st.mem_we |-> st.state == ST_IDLE && req.op == OP_WRITE)
    else $error("grid write during a query");

endmodule

`default_nettype wire
